### rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg: shared types for the ascending integer sorter
// Value type, the broadcast command and the view a cell gives its neighbours.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int unsigned ValueWidth = 32;

    typedef logic signed [ValueWidth-1:0] value_t;

    // Command broadcast along the whole chain.
    typedef struct packed {
        logic   load;    // insert value into the sorted chain
        logic   shift;   // move every entry one place towards cell 0
        value_t value;   // value being inserted
    } chain_cmd_t;

    // What a cell shows to the cells on either side of it.
    typedef struct packed {
        logic   valid;   // cell holds an entry
        logic   gt;      // entry is greater than the value being inserted
        value_t value;   // the held entry
    } cell_view_t;

endpackage

### rtl/asc_if.sv
// ----------------------------------------------------------------------------
// asc_in_if / asc_out_if: request and result channels of the sorter
// Valid/ready handshakes; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface asc_in_if;
    logic            valid;
    logic            ready;
    asc_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface asc_out_if;
    logic            valid;
    logic            ready;
    asc_pkg::value_t sorted_value;
    logic            last_of_list;
    logic            values_dropped;

    modport source (output valid, output sorted_value, output last_of_list,
                    output values_dropped, input ready);
    modport sink   (input valid, input sorted_value, input last_of_list,
                    input values_dropped, output ready);
endinterface

### rtl/asc_cell.sv
// ----------------------------------------------------------------------------
// asc_cell: one storage cell of the insertion chain
// Holds one entry; inserts, takes over its left neighbour's entry or takes
// its right neighbour's entry during draining.
// ----------------------------------------------------------------------------
module asc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  asc_pkg::chain_cmd_t   cmd,
    input  asc_pkg::cell_view_t   left,
    input  asc_pkg::cell_view_t   right,
    output asc_pkg::cell_view_t   view
);

    logic            valid_reg;
    logic            valid_next;
    asc_pkg::value_t value_reg;
    asc_pkg::value_t value_next;
    logic            gt;
    logic            take;

    assign gt   = valid_reg && (value_reg > cmd.value);
    // An entry greater than the new value moves right; the first empty cell
    // after the held entries is filled too.
    assign take = gt || (!valid_reg && left.valid);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.shift)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
        else if (cmd.load && take)
        begin
            valid_next = 1'b1;
            value_next = left.gt ? left.value : cmd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign view.valid = valid_reg;
    assign view.gt    = gt;
    assign view.value = value_reg;

endmodule

### rtl/ascending_integer_sorter.sv
// ----------------------------------------------------------------------------
// ascending_integer_sorter: streaming insertion sorter on a chain of cells
// Nonzero requests are inserted in order; a zero request drains the list.
// ----------------------------------------------------------------------------
// Loading: one request per cycle; each value sits in its place in the next cycle.
// Draining: the first result is offered in the cycle after the zero request,
//   then one result per cycle while result.ready is high, set by the one-place shift of the cell chain.
// After the last result, draining ends once cell 0 is seen empty; only then is the next request taken.
// Reset clears every cell's valid bit and the drop flag; the store is empty.
module ascending_integer_sorter #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    asc_in_if.sink     request,
    asc_out_if.source  result
);

    // Cell views, with a fixed boundary at each end of the chain. Index 0 is
    // the left boundary, index c+1 is cell c, index CAPACITY+1 the right one.
    asc_pkg::cell_view_t view [CAPACITY+2];
    asc_pkg::chain_cmd_t cmd;

    logic draining_reg;
    logic draining_next;
    logic overflow_reg;
    logic overflow_next;
    logic req_fire;
    logic res_fire;
    logic store_full;
    logic is_terminator;
    logic drain_done;

    // The left boundary behaves as a held entry that is never greater, so
    // cell 0 fills first; the right boundary is always empty.
    assign view[0].valid           = 1'b1;
    assign view[0].gt              = 1'b0;
    assign view[0].value           = '0;
    assign view[CAPACITY+1].valid  = 1'b0;
    assign view[CAPACITY+1].gt     = 1'b0;
    assign view[CAPACITY+1].value  = '0;

    genvar c;
    generate
        for (c = 0; c < CAPACITY; c++)
        begin : g_cell
            asc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (view[c]),
                .right (view[c+2]),
                .view  (view[c+1])
            );
        end
    endgenerate

    // Requests are taken only while no list is being drained.
    assign request.ready  = !draining_reg;
    assign req_fire       = request.valid && request.ready;
    assign is_terminator  = (request.value == '0);
    // The chain is full once its last cell holds an entry.
    assign store_full     = view[CAPACITY].valid;

    // Results come straight from cell 0; the last one is the cell with an
    // empty right neighbour.
    assign result.valid          = draining_reg && view[1].valid;
    assign result.sorted_value   = view[1].value;
    assign result.last_of_list   = !view[2].valid;
    assign result.values_dropped = overflow_reg;
    assign res_fire              = result.valid && result.ready;
    assign drain_done            = draining_reg && !view[1].valid;

    assign cmd.load  = req_fire && !is_terminator && !store_full;
    assign cmd.shift = res_fire;
    assign cmd.value = request.value;

    always_comb
    begin
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        if (req_fire)
        begin
            if (is_terminator)
            begin
                draining_next = 1'b1;
            end
            else if (store_full)
            begin
                overflow_next = 1'b1;
            end
        end
        else if (drain_done)
        begin
            // The whole list has gone out; the next one starts clean.
            draining_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

    // Held entries always fill the chain from cell 0 without gaps, in non-descending order.
    generate
        for (c = 1; c < CAPACITY; c++)
        begin : g_chk
            a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
                view[c+1].valid |-> view[c].valid)
                else $error("cell chain holds a gap");
            a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
                view[c+1].valid |-> !(view[c].value > view[c+1].value))
                else $error("cell chain out of order");
        end
    endgenerate

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        drain_done |=> (!overflow_reg && !draining_reg && !view[1].valid))
        else $error("drain end did not leave the sorter empty");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && result.last_of_list) |=> !result.valid)
        else $error("result offered after the last of the list");

endmodule
